@@ hw/rtl/uart_idle_timeout_frame_receiver_assert.svh @@
// Assertion macros for the idle-gap frame receiver; clock clk, reset rst_n.
`ifndef UART_IDLE_TIMEOUT_FRAME_RECEIVER_ASSERT_SVH
`define UART_IDLE_TIMEOUT_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define UITF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UITF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/uitf_pkg.sv @@
// Package: constants, op codes and item types of the idle-gap frame receiver.
package uitf_pkg;

    localparam int BUFFER_DEPTH = 320;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W        = 9;
    localparam int LEN_W        = 9;
    localparam int CMP_W        = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int BYTE_W       = 8;
    localparam int TICK_W       = 16;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [TICK_W-1:0] EXPIRE_RESET = 16'd2;
    localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] byte_value;
        logic [IDX_W-1:0]  read_index;
    } uitf_in_t;

    typedef struct packed {
        logic              frame_ready;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] read_data;
    } uitf_out_t;

    typedef struct packed {
        logic             frame_ready;
        logic [LEN_W-1:0] frame_length;
        logic             read_hit;
    } uitf_stage_t;

endpackage

@@ hw/rtl/uitf_ram.sv @@
// Generic single-port RAM with registered read.
module uitf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/uitf_ctrl.sv @@
// Frame control: flags, byte count, idle tick counter and buffer access.
module uitf_ctrl
    import uitf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  uitf_in_t          in_item,
    input  logic              cfg_valid,
    input  logic [TICK_W-1:0] cfg_data,
    output logic              cfg_ready,
    output logic              ram_we,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [BYTE_W-1:0] ram_wdata,
    output uitf_stage_t       stage
);

    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              loading_reg, loading_next;
    logic              ready_reg,   ready_next;
    logic [TICK_W-1:0] ticks_reg,   ticks_next;
    logic [TICK_W-1:0] expire_reg,  expire_next;
    logic [TICK_W-1:0] ticks_inc;
    logic              read_hit;

    assign cfg_ready = 1'b1;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign expire_next = cfg_valid ? cfg_data : expire_reg;
    assign ram_wdata = in_item.byte_value;

    always_comb
    begin
        count_next   = count_reg;
        loading_next = loading_reg;
        ready_next   = ready_reg;
        ticks_next   = ticks_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = '0;
        read_hit     = 1'b0;
        if (in_accept)
        begin
            case (in_item.op)
                OP_BYTE:
                begin
                    if (!ready_reg)
                    begin
                        if (!loading_reg)
                        begin
                            ram_we       = 1'b1;
                            count_next   = CNT_W'(1);
                            loading_next = 1'b1;
                            ticks_next   = '0;
                        end
                        else if (count_reg < CNT_W'(BUFFER_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            ram_addr   = count_reg[ADDR_W-1:0];
                            count_next = count_reg + 1'b1;
                            ticks_next = '0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (loading_reg && !ready_reg)
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc > expire_reg)
                        begin
                            loading_next = 1'b0;
                            ready_next   = 1'b1;
                        end
                    end
                end
                OP_READ:
                begin
                    if (ready_reg && (CMP_W'(in_item.read_index) < CMP_W'(count_reg)))
                    begin
                        read_hit = 1'b1;
                        ram_re   = 1'b1;
                        ram_addr = ADDR_W'(in_item.read_index);
                    end
                end
                OP_RELEASE:
                begin
                    ready_next   = 1'b0;
                    loading_next = 1'b0;
                    count_next   = '0;
                end
                default:
                begin
                    ready_next = ready_reg;
                end
            endcase
        end
    end

    assign stage.frame_ready  = ready_next;
    assign stage.frame_length = ready_next ? LEN_W'(count_next) : '0;
    assign stage.read_hit     = read_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            loading_reg <= 1'b0;
            ready_reg   <= 1'b0;
            ticks_reg   <= '0;
            expire_reg  <= EXPIRE_RESET;
        end
        else
        begin
            count_reg   <= count_next;
            loading_reg <= loading_next;
            ready_reg   <= ready_next;
            ticks_reg   <= ticks_next;
            expire_reg  <= expire_next;
        end
    end

`include "uart_idle_timeout_frame_receiver_assert.svh"

    `UITF_ASSERT_NOW(a_flags_excl, ready_reg, !loading_reg, "ready and loading both set")
    `UITF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(BUFFER_DEPTH), "count past depth")
    `UITF_ASSERT_NOW(a_no_write_ready, ram_we, !ready_reg && !ram_re, "buffer write while ready")

endmodule

@@ hw/rtl/uitf_out.sv @@
// Result pipeline: buffer read stage and output register.
module uitf_out
    import uitf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  uitf_stage_t       stage,
    input  logic [BYTE_W-1:0] ram_rdata,
    output logic              in_stall,
    output logic              in_accept,
    output logic              out_valid,
    output uitf_out_t         out_item
);

    logic        s1_valid_reg, s1_valid_next;
    uitf_stage_t s1_reg;
    logic        out_valid_reg, out_valid_next;
    uitf_out_t   out_reg;
    logic        s1_go;

    assign s1_go     = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_go);
    assign out_valid_next = s1_go ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= stage;
        end
        if (s1_go && s1_valid_reg)
        begin
            out_reg.frame_ready  <= s1_reg.frame_ready;
            out_reg.frame_length <= s1_reg.frame_length;
            out_reg.read_data    <= s1_reg.read_hit ? ram_rdata : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`include "uart_idle_timeout_frame_receiver_assert.svh"

    `UITF_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_go, s1_valid_reg, "read stage lost item")
    `UITF_ASSERT_NOW(a_stall_full, in_stall, s1_valid_reg && out_valid_reg, "stall with room")
    `UITF_ASSERT_NEXT(a_s1_drain, s1_valid_reg && s1_go, out_valid_reg, "item not moved to output")

endmodule

@@ hw/rtl/uart_idle_timeout_frame_receiver.sv @@
// Top level of the idle-gap frame receiver.
//
//   channel  direction  handshake          item
//   in       input      in_valid/in_stall  uitf_in_t: op, byte_value, read_index
//   out      output     out_valid/out_stall uitf_out_t: frame_ready, frame_length, read_data
//   cfg      input      cfg_valid/cfg_ready cfg_data: expire_ticks
//
// One item per cycle while the input is not stalled; a result passes the read stage
// and the output register before it is offered. The frame buffer is one single-port
// RAM with a registered read, used by at most one write or one read per item.
// Reset clears the flags, byte count, idle counter and sets expire_ticks to 2.
// An output stall holds the output register; the input stalls only while the read
// stage and the output register are both full and the output is stalled.
module uart_idle_timeout_frame_receiver
    import uitf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  uitf_in_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output uitf_out_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_data
);

    logic              in_accept;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    uitf_stage_t       stage;

    uitf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .stage     (stage)
    );

    uitf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    uitf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stage     (stage),
        .ram_rdata (ram_rdata),
        .in_stall  (in_stall),
        .in_accept (in_accept),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
